/* design/sbape_pkg.sv */
// ----------------------------------------------------------------------------
// sbape_pkg
// Shared widths, mode codes and constants of the stretch-blend pixel engine.
// ----------------------------------------------------------------------------
package sbape_pkg;

	localparam int unsigned ModeW   = 3;
	localparam int unsigned PixW    = 32;
	localparam int unsigned CountW  = 9;
	localparam int unsigned StepW   = 24;
	localparam int unsigned FracW   = 16;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned ChanW   = 8;

	localparam logic [ModeW-1:0] MODE_FRAME  = 3'd0;
	localparam logic [ModeW-1:0] MODE_ROW    = 3'd1;
	localparam logic [ModeW-1:0] MODE_REPLAY = 3'd2;
	localparam logic [ModeW-1:0] MODE_SRC    = 3'd3;
	localparam logic [ModeW-1:0] MODE_DST    = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_STEP_X = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_STEP_Y = 1'd1;

	localparam logic [FracW-1:0] HALF_STEP  = 16'h8000;
	localparam logic [StepW-1:0] STEP_RESET = 24'h010000;
	localparam logic [ChanW-1:0] ALPHA_FULL = 8'hff;
	localparam logic [ChanW-1:0] ALPHA_NONE = 8'h00;

endpackage

/* design/sbape_cfg_if.sv */
// ----------------------------------------------------------------------------
// sbape_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface sbape_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sbape_pkg::CfgIdxW-1:0]       index;
	logic [sbape_pkg::StepW-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* design/sbape_in_if.sv */
// ----------------------------------------------------------------------------
// sbape_in_if
// Input item channel: mode and pixel with valid/ready.
// ----------------------------------------------------------------------------
interface sbape_in_if;
	logic                          valid;
	logic                          ready;
	logic [sbape_pkg::ModeW-1:0]   mode;
	logic [sbape_pkg::PixW-1:0]    pixel;

	modport source (output valid, mode, pixel, input ready);
	modport sink   (input valid, mode, pixel, output ready);
endinterface

/* design/sbape_out_if.sv */
// ----------------------------------------------------------------------------
// sbape_out_if
// Result channel: repeat count, blended pixel and write enable.
// ----------------------------------------------------------------------------
interface sbape_out_if;
	logic                          valid;
	logic                          ready;
	logic [sbape_pkg::CountW-1:0]  repeat_count;
	logic [sbape_pkg::PixW-1:0]    out_pixel;
	logic                          write_enable;

	modport source (output valid, repeat_count, out_pixel, write_enable, input ready);
	modport sink   (input valid, repeat_count, out_pixel, write_enable, output ready);
endinterface

/* design/stretch_blend_argb_pixel_engine_unit.sv */
// ----------------------------------------------------------------------------
// stretch_blend_argb_pixel_engine_unit
// Nearest-neighbor step accumulators and ARGB8888 alpha blend. An input
// transaction passes first the input register and then the result register.
// Throughput: one transaction per cycle unless the result channel stalls; the
// accumulator add and the four 9x8 blend multiplies sit between the input and
// result registers. Reset (arst_n low): pipeline empty, steps 0x10000,
// fractions one half, latched source zero. Config writes are always ready.
// ----------------------------------------------------------------------------
module stretch_blend_argb_pixel_engine_unit (
	input  logic               clk,
	input  logic               arst_n,
	sbape_cfg_if.sink          cfg,
	sbape_in_if.sink           src,
	sbape_out_if.source        dst
);

	localparam int unsigned SumW = sbape_pkg::StepW + 1;

	logic [sbape_pkg::StepW-1:0]  step_x_q, step_y_q;
	logic [sbape_pkg::FracW-1:0]  vfrac_q, hfrac_q;
	logic [sbape_pkg::PixW-1:0]   latch_q;

	logic                         valid_s1;
	logic [sbape_pkg::ModeW-1:0]  mode_s1;
	logic [sbape_pkg::PixW-1:0]   pixel_s1;

	logic                         valid_s2;
	logic [sbape_pkg::CountW-1:0] count_s2;
	logic [sbape_pkg::PixW-1:0]   pixel_s2;
	logic                         we_s2;

	logic                         adv_s1;
	logic [SumW-1:0]              sum_v, sum_h;
	logic [sbape_pkg::CountW-1:0] count_d;
	logic [sbape_pkg::PixW-1:0]   pixel_d;
	logic                         we_d;
	logic [sbape_pkg::PixW-1:0]   blend;
	logic [sbape_pkg::ChanW-1:0]  alpha;
	logic [sbape_pkg::ChanW:0]    inv_alpha;

	function automatic logic [sbape_pkg::ChanW-1:0] blend_chan(
		input logic [sbape_pkg::ChanW:0]   inv,
		input logic [sbape_pkg::ChanW-1:0] d,
		input logic [sbape_pkg::ChanW-1:0] s
	);
		logic [2*sbape_pkg::ChanW:0] prod;
		logic [sbape_pkg::ChanW:0]   c;
		prod = {{sbape_pkg::ChanW{1'b0}}, inv} * {{(sbape_pkg::ChanW+1){1'b0}}, d};
		c    = prod[2*sbape_pkg::ChanW:sbape_pkg::ChanW] + {1'b0, s};
		return c[sbape_pkg::ChanW] ? {sbape_pkg::ChanW{1'b1}} : c[sbape_pkg::ChanW-1:0];
	endfunction

	assign cfg.ready    = 1'b1;
	assign adv_s1       = valid_s1 && (!valid_s2 || dst.ready);
	assign src.ready    = !valid_s1 || adv_s1;

	assign sum_v     = {1'b0, step_y_q} + {{(SumW-sbape_pkg::FracW){1'b0}}, vfrac_q};
	assign sum_h     = {1'b0, step_x_q} + {{(SumW-sbape_pkg::FracW){1'b0}}, hfrac_q};
	assign alpha     = latch_q[31:24];
	assign inv_alpha = 9'h100 - {1'b0, alpha};
	assign blend     = {blend_chan(inv_alpha, pixel_s1[31:24], alpha),
		blend_chan(inv_alpha, pixel_s1[23:16], latch_q[23:16]),
		blend_chan(inv_alpha, pixel_s1[15:8],  latch_q[15:8]),
		blend_chan(inv_alpha, pixel_s1[7:0],   latch_q[7:0])};

	always_comb begin
		count_d = '0;
		pixel_d = '0;
		we_d    = 1'b0;
		unique case (mode_s1)
			sbape_pkg::MODE_ROW: begin
				count_d = sum_v[SumW-1:sbape_pkg::FracW];
			end
			sbape_pkg::MODE_SRC: begin
				count_d = sum_h[SumW-1:sbape_pkg::FracW];
			end
			sbape_pkg::MODE_DST: begin
				if (alpha == sbape_pkg::ALPHA_FULL) begin
					pixel_d = latch_q;
					we_d    = 1'b1;
				end else if (alpha == sbape_pkg::ALPHA_NONE) begin
					pixel_d = pixel_s1;
				end else begin
					pixel_d = blend;
					we_d    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= sbape_pkg::STEP_RESET;
			step_y_q <= sbape_pkg::STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				sbape_pkg::REG_STEP_X: step_x_q <= cfg.data;
				sbape_pkg::REG_STEP_Y: step_y_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vfrac_q <= sbape_pkg::HALF_STEP;
			hfrac_q <= sbape_pkg::HALF_STEP;
			latch_q <= '0;
		end else if (adv_s1) begin
			unique case (mode_s1)
				sbape_pkg::MODE_FRAME:  vfrac_q <= sbape_pkg::HALF_STEP;
				sbape_pkg::MODE_ROW:    vfrac_q <= sum_v[sbape_pkg::FracW-1:0];
				sbape_pkg::MODE_REPLAY: hfrac_q <= sbape_pkg::HALF_STEP;
				sbape_pkg::MODE_SRC: begin
					hfrac_q <= sum_h[sbape_pkg::FracW-1:0];
					latch_q <= pixel_s1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (src.ready)
				valid_s1 <= src.valid;
			if (!valid_s2 || dst.ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			mode_s1  <= src.mode;
			pixel_s1 <= src.pixel;
		end
		if (adv_s1) begin
			count_s2 <= count_d;
			pixel_s2 <= pixel_d;
			we_s2    <= we_d;
		end
	end

	assign dst.valid        = valid_s2;
	assign dst.repeat_count = count_s2;
	assign dst.out_pixel    = pixel_s2;
	assign dst.write_enable = we_s2;

	// checks
	a_we_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && we_s2 |-> count_s2 == '0)
		else $error("write enable with nonzero repeat count");

	a_count_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && count_s2 != '0 |-> pixel_s2 == '0)
		else $error("repeat count with nonzero pixel");

	a_frame_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode_s1 == sbape_pkg::MODE_FRAME |=> vfrac_q == sbape_pkg::HALF_STEP)
		else $error("frame start did not reset vertical fraction");

	a_src_latch: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode_s1 == sbape_pkg::MODE_SRC |=> latch_q == $past(pixel_s1))
		else $error("source pixel not latched");

endmodule

/* tb/sbape_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbape_result_checker
// Watches the register, item and result channels of the stretch-blend pixel
// engine. It keeps its own copy of the step registers, accumulator fractions
// and latched source, works out the result of every accepted item, and checks
// each result transaction, field by field, against the oldest outstanding one.
// ----------------------------------------------------------------------------
module sbape_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	sbape_cfg_if        cfg,
	sbape_in_if         src,
	sbape_out_if        dst,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [sbape_pkg::CountW-1:0] repeat_count;
		logic [sbape_pkg::PixW-1:0]   out_pixel;
		logic                         write_enable;
	} engine_result_t;

	localparam logic [sbape_pkg::ChanW-1:0] CHAN_MAX = '1;

	logic [sbape_pkg::StepW-1:0] step_h;
	logic [sbape_pkg::StepW-1:0] step_v;
	logic [sbape_pkg::FracW-1:0] frac_h;
	logic [sbape_pkg::FracW-1:0] frac_v;
	logic [sbape_pkg::PixW-1:0]  held_src;

	engine_result_t queued_results[$];

	function automatic logic [sbape_pkg::ChanW-1:0] blend_chan(
		input logic [sbape_pkg::ChanW:0]   inv,
		input logic [sbape_pkg::ChanW-1:0] d,
		input logic [sbape_pkg::ChanW-1:0] s
	);
		logic [2*sbape_pkg::ChanW:0] prod;
		logic [sbape_pkg::ChanW+1:0] total;
		prod  = {{sbape_pkg::ChanW{1'b0}}, inv} * {{(sbape_pkg::ChanW+1){1'b0}}, d};
		total = {1'b0, prod[2*sbape_pkg::ChanW:sbape_pkg::ChanW]} + {2'b00, s};
		return (total > {2'b00, CHAN_MAX}) ? CHAN_MAX : total[sbape_pkg::ChanW-1:0];
	endfunction

	function automatic engine_result_t advance_engine(
		input logic [sbape_pkg::ModeW-1:0] mode,
		input logic [sbape_pkg::PixW-1:0]  pixel
	);
		engine_result_t              res;
		logic [sbape_pkg::StepW:0]   acc;
		logic [sbape_pkg::ChanW-1:0] alpha;
		logic [sbape_pkg::ChanW:0]   inv;
		res = '0;
		case (mode)
			sbape_pkg::MODE_FRAME: begin
				frac_v = sbape_pkg::HALF_STEP;
			end
			sbape_pkg::MODE_ROW: begin
				acc              = {{(sbape_pkg::StepW+1-sbape_pkg::FracW){1'b0}}, frac_v}
					+ {1'b0, step_v};
				res.repeat_count = acc[sbape_pkg::StepW:sbape_pkg::FracW];
				frac_v           = acc[sbape_pkg::FracW-1:0];
			end
			sbape_pkg::MODE_REPLAY: begin
				frac_h = sbape_pkg::HALF_STEP;
			end
			sbape_pkg::MODE_SRC: begin
				held_src         = pixel;
				acc              = {{(sbape_pkg::StepW+1-sbape_pkg::FracW){1'b0}}, frac_h}
					+ {1'b0, step_h};
				res.repeat_count = acc[sbape_pkg::StepW:sbape_pkg::FracW];
				frac_h           = acc[sbape_pkg::FracW-1:0];
			end
			sbape_pkg::MODE_DST: begin
				alpha = held_src[4*sbape_pkg::ChanW-1:3*sbape_pkg::ChanW];
				if (alpha == sbape_pkg::ALPHA_FULL) begin
					res.out_pixel    = held_src;
					res.write_enable = 1'b1;
				end else if (alpha == sbape_pkg::ALPHA_NONE) begin
					res.out_pixel    = pixel;
					res.write_enable = 1'b0;
				end else begin
					inv = {1'b1, {sbape_pkg::ChanW{1'b0}}} - {1'b0, alpha};
					res.out_pixel = {
						blend_chan(inv, pixel[4*sbape_pkg::ChanW-1:3*sbape_pkg::ChanW], alpha),
						blend_chan(inv, pixel[3*sbape_pkg::ChanW-1:2*sbape_pkg::ChanW],
							held_src[3*sbape_pkg::ChanW-1:2*sbape_pkg::ChanW]),
						blend_chan(inv, pixel[2*sbape_pkg::ChanW-1:sbape_pkg::ChanW],
							held_src[2*sbape_pkg::ChanW-1:sbape_pkg::ChanW]),
						blend_chan(inv, pixel[sbape_pkg::ChanW-1:0],
							held_src[sbape_pkg::ChanW-1:0])
					};
					res.write_enable = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		engine_result_t oldest;
		engine_result_t seen;
		if (!arst_n) begin
			step_h     = sbape_pkg::STEP_RESET;
			step_v     = sbape_pkg::STEP_RESET;
			frac_h     = sbape_pkg::HALF_STEP;
			frac_v     = sbape_pkg::HALF_STEP;
			held_src   = '0;
			fail_count = 0;
			queued_results.delete();
		end else begin
			if (dst.valid && dst.ready) begin
				seen = '{dst.repeat_count, dst.out_pixel, dst.write_enable};
				if (queued_results.size() == 0) begin
					$error("result transaction with none outstanding");
					fail_count = fail_count + 1;
				end else begin
					oldest = queued_results.pop_front();
					if (seen.repeat_count !== oldest.repeat_count) begin
						$error("repeat_count: expected %0d, actual %0d",
							oldest.repeat_count, seen.repeat_count);
						fail_count = fail_count + 1;
					end
					if (seen.out_pixel !== oldest.out_pixel) begin
						$error("out_pixel: expected %08h, actual %08h",
							oldest.out_pixel, seen.out_pixel);
						fail_count = fail_count + 1;
					end
					if (seen.write_enable !== oldest.write_enable) begin
						$error("write_enable: expected %0b, actual %0b",
							oldest.write_enable, seen.write_enable);
						fail_count = fail_count + 1;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sbape_pkg::REG_STEP_X: step_h = cfg.data;
					sbape_pkg::REG_STEP_Y: step_v = cfg.data;
					default: ;
				endcase
			end
			if (src.valid && src.ready)
				queued_results.push_back(advance_engine(src.mode, src.pixel));
		end
		pending = queued_results.size();
	end

endmodule

/* tb/tb_stretch_blend_argb_pixel_engine_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stretch_blend_argb_pixel_engine_unit
// Drives the stretch-blend pixel engine with a directed opening sequence and
// then random frames (frame start, rows, replays, source and destination
// pixels) mixed with stray items, across several step settings and with
// random sender gaps and receiver stalls. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_stretch_blend_argb_pixel_engine_unit;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [sbape_pkg::ModeW-1:0] MODE_SPARE_LO =
		sbape_pkg::MODE_DST + sbape_pkg::ModeW'(1);
	localparam logic [sbape_pkg::ModeW-1:0] MODE_SPARE_HI = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatch_count;
	int unsigned results_outstanding;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	sbape_cfg_if cfg_ch ();
	sbape_in_if  item_ch ();
	sbape_out_if res_ch ();

	stretch_blend_argb_pixel_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.src    (item_ch),
		.dst    (res_ch)
	);

	sbape_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.src        (item_ch),
		.dst        (res_ch),
		.fail_count (mismatch_count),
		.pending    (results_outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99, 0) >= stall_pct);

	task automatic send_item(input logic [sbape_pkg::ModeW-1:0] mode,
		input logic [sbape_pkg::PixW-1:0] pixel);
		while ($urandom_range(99, 0) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode  <= mode;
		item_ch.pixel <= pixel;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [sbape_pkg::CfgIdxW-1:0] idx,
		input logic [sbape_pkg::StepW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (results_outstanding != 0);
	endtask

	function automatic logic [sbape_pkg::PixW-1:0] rand_source();
		logic [sbape_pkg::PixW-1:0] p;
		p = $urandom;
		case ($urandom_range(3, 0))
			0: p[sbape_pkg::PixW-1:sbape_pkg::PixW-sbape_pkg::ChanW] = sbape_pkg::ALPHA_NONE;
			1: p[sbape_pkg::PixW-1:sbape_pkg::PixW-sbape_pkg::ChanW] = sbape_pkg::ALPHA_FULL;
			default: ;
		endcase
		return p;
	endfunction

	// well-formed frame: rows, each replayed, each with source/destination runs
	task automatic send_frame();
		int rows;
		int replays;
		int pixels;
		int dsts;
		send_item(sbape_pkg::MODE_FRAME, $urandom);
		rows = $urandom_range(3, 1);
		for (int r = 0; r < rows; r++) begin
			send_item(sbape_pkg::MODE_ROW, $urandom);
			replays = $urandom_range(2, 1);
			for (int k = 0; k < replays; k++) begin
				send_item(sbape_pkg::MODE_REPLAY, $urandom);
				pixels = $urandom_range(4, 1);
				for (int p = 0; p < pixels; p++) begin
					send_item(sbape_pkg::MODE_SRC, rand_source());
					dsts = $urandom_range(3, 1);
					for (int d = 0; d < dsts; d++)
						send_item(sbape_pkg::MODE_DST, $urandom);
				end
			end
		end
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(9, 0) == 0)
				send_item(sbape_pkg::ModeW'($urandom_range(MODE_SPARE_HI,
					sbape_pkg::MODE_FRAME)), $urandom);
			else
				send_frame();
		end
	endtask

	task automatic run_phase(
		input logic [sbape_pkg::StepW-1:0] sx,
		input logic [sbape_pkg::StepW-1:0] sy,
		input int unsigned                 idle,
		input int unsigned                 stall,
		input int unsigned                 n
	);
		drain();
		write_reg(sbape_pkg::REG_STEP_X, sx);
		write_reg(sbape_pkg::REG_STEP_Y, sy);
		cfg_ch.valid <= 1'b0;
		idle_pct  = idle;
		stall_pct = stall;
		run_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= sbape_pkg::REG_STEP_X;
		cfg_ch.data   <= '0;
		item_ch.valid <= 1'b0;
		item_ch.mode  <= sbape_pkg::MODE_FRAME;
		item_ch.pixel <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset steps; destination before any source sees a transparent zero
		send_item(sbape_pkg::MODE_DST,    32'hffffffff);
		send_item(sbape_pkg::MODE_FRAME,  32'h00000000);
		send_item(sbape_pkg::MODE_ROW,    32'hffffffff);
		send_item(sbape_pkg::MODE_REPLAY, 32'h00000000);
		send_item(sbape_pkg::MODE_SRC,    32'hff123456);
		send_item(sbape_pkg::MODE_DST,    32'h00000000);
		send_item(sbape_pkg::MODE_SRC,    32'h00abcdef);
		send_item(sbape_pkg::MODE_DST,    32'h89abcdef);
		send_item(sbape_pkg::MODE_SRC,    32'h80ffffff);
		send_item(sbape_pkg::MODE_DST,    32'hffffffff);
		send_item(sbape_pkg::MODE_DST,    32'h00000000);
		send_item(sbape_pkg::MODE_SRC,    32'h01000000);
		send_item(sbape_pkg::MODE_DST,    32'hffffffff);
		send_item(sbape_pkg::MODE_SRC,    32'hfe010203);
		send_item(sbape_pkg::MODE_DST,    32'h7f7f7f7f);
		send_item(MODE_SPARE_LO,          32'hffffffff);
		send_item(MODE_SPARE_HI,          32'hffffffff);
		send_item(sbape_pkg::MODE_DST,    32'h12345678);
		send_item(sbape_pkg::MODE_ROW,    32'h00000000);
		send_item(sbape_pkg::MODE_FRAME,  32'hffffffff);
		send_item(sbape_pkg::MODE_SRC,    32'h00000000);
		send_item(sbape_pkg::MODE_DST,    32'hffffffff);
		run_random(120);

		run_phase(24'hffffff, 24'hffffff, 67, 0, 125);
		run_phase(24'h000000, 24'h000000, 0, 67, 125);
		run_phase(sbape_pkg::StepW'($urandom), sbape_pkg::StepW'($urandom), 32, 32, 125);
		run_phase(sbape_pkg::StepW'($urandom_range(24'h040000, 24'h010000)),
			sbape_pkg::StepW'($urandom_range(24'h010000, 24'h004000)), 0, 0, 125);
		run_phase(sbape_pkg::StepW'($urandom_range(24'h010000, 24'h004000)),
			sbape_pkg::StepW'($urandom_range(24'h040000, 24'h010000)), 32, 32, 125);

		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && results_outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* stretch_blend_argb_pixel_engine_unit.f */
design/sbape_pkg.sv
design/sbape_cfg_if.sv
design/sbape_in_if.sv
design/sbape_out_if.sv
design/stretch_blend_argb_pixel_engine_unit.sv
tb/sbape_result_checker.sv
tb/tb_stretch_blend_argb_pixel_engine_unit.sv
